>>> hdl/wes_pkg.sv
// Package: widths, weight register indexes, pair class function and reset weights.
package wes_pkg;

	localparam int CODE_BITS   = 16;
	localparam int SCORE_BITS  = 24;
	localparam int COUNT_BITS  = 16;
	localparam int WEIGHT_BITS = 8;
	localparam int NUM_WEIGHTS = 8;
	localparam int IDX_BITS    = $clog2(NUM_WEIGHTS);
	localparam int ADDR_BITS   = IDX_BITS + 2;
	localparam int DATA_BITS   = 32;

	typedef logic [IDX_BITS-1:0]           wclass_t;
	typedef logic signed [WEIGHT_BITS-1:0] weight_t;
	typedef logic [CODE_BITS-1:0]          code_t;
	typedef logic signed [SCORE_BITS-1:0]  score_t;
	typedef logic [COUNT_BITS-1:0]         count_t;

	// register indexes, also the class codes
	localparam wclass_t W_SAME       = 3'd0;
	localparam wclass_t W_BOTH_UNED  = 3'd1;
	localparam wclass_t W_ONE_MISS   = 3'd2;
	localparam wclass_t W_ONE_AMB    = 3'd3;
	localparam wclass_t W_DIFF       = 3'd4;
	localparam wclass_t W_UNED_VS_ED = 3'd5;
	localparam wclass_t W_BOTH_MISS  = 3'd6;
	localparam wclass_t W_BOTH_AMB   = 3'd7;

	localparam code_t CODE_UNEDITED  = CODE_BITS'(0);
	localparam code_t CODE_MISSING   = CODE_BITS'(1);
	localparam code_t CODE_AMBIGUOUS = CODE_BITS'(2);

	typedef struct packed {
		weight_t same_edit;
		weight_t both_unedited;
		weight_t one_missing;
		weight_t one_ambiguous;
		weight_t diff_edits;
		weight_t unedited_vs_edited;
		weight_t both_missing;
		weight_t both_ambiguous;
	} weights_t;

	localparam weights_t WEIGHTS_RESET = '{
		same_edit:          8'sd5,
		both_unedited:      8'sd1,
		one_missing:        8'sd0,
		one_ambiguous:      8'sd0,
		diff_edits:         -8'sd5,
		unedited_vs_edited: -8'sd2,
		both_missing:       8'sd0,
		both_ambiguous:     8'sd0
	};

	function automatic wclass_t pick_class(input code_t a, input code_t b);
		logic a0, b0, a1, b1, a2, b2;
		wclass_t c;
		a0 = (a == CODE_UNEDITED);
		b0 = (b == CODE_UNEDITED);
		a1 = (a == CODE_MISSING);
		b1 = (b == CODE_MISSING);
		a2 = (a == CODE_AMBIGUOUS);
		b2 = (b == CODE_AMBIGUOUS);
		if (a0 && b0)
			c = W_BOTH_UNED;
		else if ((a0 || b0) && !a1 && !b1 && !a2 && !b2)
			c = W_UNED_VS_ED;
		else if (a1 && b1)
			c = W_BOTH_MISS;
		else if (a1 || b1)
			c = W_ONE_MISS;
		else if (a2 && b2)
			c = W_BOTH_AMB;
		else if (a2 || b2)
			c = W_ONE_AMB;
		else if (a == b)
			c = W_SAME;
		else
			c = W_DIFF;
		return c;
	endfunction

	function automatic weight_t pick_weight(input weights_t w, input wclass_t c);
		weight_t r;
		case (c)
			W_SAME:       r = w.same_edit;
			W_BOTH_UNED:  r = w.both_unedited;
			W_ONE_MISS:   r = w.one_missing;
			W_ONE_AMB:    r = w.one_ambiguous;
			W_DIFF:       r = w.diff_edits;
			W_UNED_VS_ED: r = w.unedited_vs_edited;
			W_BOTH_MISS:  r = w.both_missing;
			W_BOTH_AMB:   r = w.both_ambiguous;
			default:      r = w.same_edit;
		endcase
		return r;
	endfunction

endpackage

>>> hdl/wes_pair_if.sv
// Interface: input channel carrying one pair of target codes per transaction.
interface wes_pair_if;
	logic                      valid;
	logic                      ready;
	logic [wes_pkg::CODE_BITS-1:0] code_a;
	logic [wes_pkg::CODE_BITS-1:0] code_b;
	logic                      last;

	modport source(output valid, code_a, code_b, last, input ready);
	modport sink(input valid, code_a, code_b, last, output ready);
endinterface

>>> hdl/wes_result_if.sv
// Interface: result channel carrying the score and pair count of one cell pair.
interface wes_result_if;
	logic                           valid;
	logic                           ready;
	logic signed [wes_pkg::SCORE_BITS-1:0] score;
	logic [wes_pkg::COUNT_BITS-1:0]        pair_count;

	modport source(output valid, score, pair_count, input ready);
	modport sink(input valid, score, pair_count, output ready);
endinterface

>>> hdl/weighted_edit_similarity_core.sv
// Weighted edit similarity core: classifies code pairs and accumulates weighted score.
// The pair carrying last is registered in stage 1, and its result is then registered in the result register.
// Throughput: one pair per cycle; stalls only when a finished result is still
// held in the output register and the next last pair reaches the adder stage.
// Reset (arst_n low): clears pipeline valids, score and count, loads default weights.
module weighted_edit_similarity_core (
	input  logic                           clk,
	input  logic                           arst_n,
	wes_pair_if.sink                       pair,
	wes_result_if.source                   result,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [wes_pkg::ADDR_BITS-1:0]  paddr,
	input  logic [wes_pkg::DATA_BITS-1:0]  pwdata,
	output logic [wes_pkg::DATA_BITS-1:0]  prdata,
	output logic                           pready
);
	import wes_pkg::*;

	weights_t weights_q;

	logic  valid_s1;
	code_t code_a_s1;
	code_t code_b_s1;
	logic  last_s1;

	score_t acc_score_q;
	count_t acc_count_q;

	logic   res_valid_q;
	score_t res_score_q;
	count_t res_count_q;

	logic                    advance;
	wclass_t                 cls;
	weight_t                 wsel;
	logic signed [SCORE_BITS:0] sum_w;
	score_t                  new_score;
	count_t                  new_count;
	wclass_t                 reg_idx;
	weight_t                 rd_weight;

	// config port
	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_BITS-1:2];

	always_comb begin
		rd_weight = pick_weight(weights_q, reg_idx);
		prdata    = DATA_BITS'(signed'(rd_weight));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weights_q <= WEIGHTS_RESET;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				W_SAME:       weights_q.same_edit          <= weight_t'(pwdata[WEIGHT_BITS-1:0]);
				W_BOTH_UNED:  weights_q.both_unedited      <= weight_t'(pwdata[WEIGHT_BITS-1:0]);
				W_ONE_MISS:   weights_q.one_missing        <= weight_t'(pwdata[WEIGHT_BITS-1:0]);
				W_ONE_AMB:    weights_q.one_ambiguous      <= weight_t'(pwdata[WEIGHT_BITS-1:0]);
				W_DIFF:       weights_q.diff_edits         <= weight_t'(pwdata[WEIGHT_BITS-1:0]);
				W_UNED_VS_ED: weights_q.unedited_vs_edited <= weight_t'(pwdata[WEIGHT_BITS-1:0]);
				W_BOTH_MISS:  weights_q.both_missing       <= weight_t'(pwdata[WEIGHT_BITS-1:0]);
				W_BOTH_AMB:   weights_q.both_ambiguous     <= weight_t'(pwdata[WEIGHT_BITS-1:0]);
				default:      weights_q <= weights_q;
			endcase
		end
	end

	// stage 1 moves on unless it holds a last pair and the result slot is taken
	assign advance    = valid_s1 && (!last_s1 || !res_valid_q || result.ready);
	assign pair.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pair.ready) begin
			valid_s1 <= pair.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pair.valid && pair.ready) begin
			code_a_s1 <= pair.code_a;
			code_b_s1 <= pair.code_b;
			last_s1   <= pair.last;
		end
	end

	// classify, add, saturate
	always_comb begin
		cls   = pick_class(code_a_s1, code_b_s1);
		wsel  = pick_weight(weights_q, cls);
		sum_w = (SCORE_BITS+1)'(acc_score_q) + (SCORE_BITS+1)'(wsel);
		if (sum_w[SCORE_BITS] != sum_w[SCORE_BITS-1])
			new_score = sum_w[SCORE_BITS] ? {1'b1, {(SCORE_BITS-1){1'b0}}}
			                              : {1'b0, {(SCORE_BITS-1){1'b1}}};
		else
			new_score = sum_w[SCORE_BITS-1:0];
		new_count = (acc_count_q == '1) ? acc_count_q : acc_count_q + COUNT_BITS'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_score_q <= '0;
			acc_count_q <= '0;
		end else if (advance) begin
			if (last_s1) begin
				acc_score_q <= '0;
				acc_count_q <= '0;
			end else begin
				acc_score_q <= new_score;
				acc_count_q <= new_count;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			res_score_q <= new_score;
			res_count_q <= new_count;
		end
	end

	assign result.valid      = res_valid_q;
	assign result.score      = res_score_q;
	assign result.pair_count = res_count_q;

endmodule
